// ===== rtl/bsfs_pkg.sv =====
package bsfs_pkg;

  // Default depth of the delimiter mark, in bytes.
  localparam int MAX_MARK_BYTES_DEF = 8;

  // Register index width and held byte counter width.
  localparam int CFG_IDX_W = 3;
  localparam int HELD_W    = 17;
  localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMING_ENABLE    = 3'd0,
    REG_FIXED_LENGTH_MODE = 3'd1,
    REG_FRAME_LENGTH      = 3'd2,
    REG_MARK_PATTERN      = 3'd3,
    REG_MARK_LENGTH       = 3'd4,
    REG_HOLD_LIMIT        = 3'd5
  } reg_idx_t;

  // Reason a frame ended on a byte.
  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_LENGTH   = 3'd1,
    CAUSE_MARK     = 3'd2,
    CAUSE_OVERFLOW = 3'd3,
    CAUSE_CHUNK    = 3'd4
  } cause_t;

  // Current configuration, as seen by the framer.
  typedef struct packed {
    logic        framing_enable;
    logic        fixed_length_mode;
    logic [15:0] frame_length;
    logic [63:0] mark_pattern;
    logic [3:0]  mark_length;
    logic [15:0] hold_limit;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    cause_t     end_cause;
  } result_t;

  // One input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } in_word_t;

endpackage

// ===== rtl/bsfs_if.sv =====
// Input byte channel.
interface bsfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, output data_byte, output chunk_last, input ready);
  modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

// Result byte channel.
interface bsfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;
  logic [2:0] end_cause;

  modport source (output valid, output out_byte, output frame_last, output end_cause,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_last, input end_cause,
                  output ready);
endinterface

// Configuration write channel.
interface bsfs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bsfs_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bsfs_cfg_regs.sv =====
module bsfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_valid,
  output logic                           wr_ready,
  input  logic [bsfs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [63:0]                    wr_data,
  output bsfs_pkg::cfg_t                 cfg
);
  import bsfs_pkg::*;

  // Writes are always taken; wr_ready is held high.
  assign wr_ready = 1'b1;

  // Register file; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.framing_enable    <= 1'b0;
      cfg.fixed_length_mode <= 1'b0;
      cfg.frame_length      <= 16'd1;
      cfg.mark_pattern      <= 64'd0;
      cfg.mark_length       <= 4'd0;
      cfg.hold_limit        <= 16'd0;
    end else if (wr_valid) begin
      case (reg_idx_t'(wr_index))
        REG_FRAMING_ENABLE:    cfg.framing_enable    <= wr_data[0];
        REG_FIXED_LENGTH_MODE: cfg.fixed_length_mode <= wr_data[0];
        REG_FRAME_LENGTH:      cfg.frame_length      <= wr_data[15:0];
        REG_MARK_PATTERN:      cfg.mark_pattern      <= wr_data;
        REG_MARK_LENGTH:       cfg.mark_length       <= wr_data[3:0];
        REG_HOLD_LIMIT:        cfg.hold_limit        <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bsfs_stage.sv =====
module bsfs_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         valid;
  logic [W-1:0] data;

  // The stage takes a word when empty or when its word leaves this cycle.
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

// ===== rtl/bsfs_framer.sv =====
module bsfs_framer #(
  parameter int MAX_MARK_BYTES = bsfs_pkg::MAX_MARK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bsfs_pkg::cfg_t      cfg,
  input  logic                fire,
  input  bsfs_pkg::in_word_t  word,
  output bsfs_pkg::result_t   res
);
  import bsfs_pkg::*;

  localparam int RW = 8 * MAX_MARK_BYTES;
  localparam logic [3:0] MAX_LEN = 4'(MAX_MARK_BYTES);

  logic [HELD_W-1:0] held_count, held_count_next;
  logic [RW-1:0]     recent_bytes, recent_bytes_next;
  logic [RW+7:0]     shifted;
  logic [HELD_W-1:0] count;
  logic [15:0]       len;
  logic [3:0]        mlen;
  logic [MAX_MARK_BYTES-1:0] byte_ok;
  logic              mark_hit;
  cause_t            cause;

  // Shift the new byte into the recent window, newest in the low byte.
  assign shifted = {recent_bytes, word.data_byte};

  // Per-byte mark compare over the clamped mark length.
  always_comb begin
    for (int i = 0; i < MAX_MARK_BYTES; i++) begin
      byte_ok[i] = (4'(i) >= mlen) ||
                   (shifted[8*i +: 8] == cfg.mark_pattern[8*i +: 8]);
    end
  end

  assign mark_hit = &byte_ok;

  // Frame end decision and next state.
  always_comb begin
    count = (held_count == HELD_MAX) ? held_count : held_count + 1'b1;
    len   = (cfg.frame_length == 16'd0) ? 16'd1 : cfg.frame_length;
    mlen  = (cfg.mark_length > MAX_LEN) ? MAX_LEN : cfg.mark_length;
    cause = CAUSE_NONE;
    if (!cfg.framing_enable) begin
      if (word.chunk_last) cause = CAUSE_CHUNK;
      held_count_next   = '0;
      recent_bytes_next = '0;
    end else begin
      recent_bytes_next = shifted[RW-1:0];
      if (cfg.fixed_length_mode) begin
        if (count >= {1'b0, len}) cause = CAUSE_LENGTH;
      end else if (mlen == 4'd0) begin
        if (word.chunk_last) cause = CAUSE_CHUNK;
      end else if (count >= {{(HELD_W-4){1'b0}}, mlen} && mark_hit) begin
        cause = CAUSE_MARK;
      end
      if (cause == CAUSE_NONE && count > {1'b0, cfg.hold_limit}) begin
        cause = CAUSE_OVERFLOW;
      end
      held_count_next = (cause == CAUSE_NONE) ? count : '0;
    end
    res.out_byte   = word.data_byte;
    res.frame_last = (cause != CAUSE_NONE);
    res.end_cause  = cause;
  end

  // Framing state advances only on a word that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= '0;
      recent_bytes <= '0;
    end else if (fire) begin
      held_count   <= held_count_next;
      recent_bytes <= recent_bytes_next;
    end
  end

  // A disabled framer keeps no held bytes.
  a_disabled_clears: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg.framing_enable |=> held_count == '0)
    else $error("held count not cleared while framing is disabled");

  // A frame end restarts the count.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_last |=> held_count == '0)
    else $error("held count not cleared after a frame end");

  // A byte that ends no frame while framing stays counted.
  a_hold_counts: assert property (@(posedge clk) disable iff (rst)
    fire && cfg.framing_enable && !res.frame_last |=> held_count != '0)
    else $error("held byte lost from the count");

  // State holds between words.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(held_count) && $stable(recent_bytes))
    else $error("framing state changed without a word");

endmodule

// ===== rtl/byte_stream_frame_splitter_top.sv =====
// A word accepted on rx passes through the input stage and then the result
// register before it is offered on tx.
// Throughput: one byte per cycle while tx is ready; the input stage, the
// framer's counter and mark compare, and the result register each take one
// word per cycle. A stall on tx holds the result register; once both stages
// are full, rx ready drops in the same cycle as tx ready.
// Reset (rst, synchronous, active high) empties both stages, clears the held
// count and the recent bytes, and resets the configuration registers.
module byte_stream_frame_splitter_top #(
  parameter int MAX_MARK_BYTES = bsfs_pkg::MAX_MARK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bsfs_in_if.sink     rx,
  bsfs_out_if.source  tx,
  bsfs_cfg_if.sink    cfg
);
  import bsfs_pkg::*;

  cfg_t     cfg_q;
  in_word_t rx_word, held_word;
  result_t  res, tx_word;
  logic     mid_valid, mid_ready, fire;

  // Configuration registers.
  bsfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // Input register.
  assign rx_word.data_byte  = rx.data_byte;
  assign rx_word.chunk_last = rx.chunk_last;

  bsfs_stage #(.W($bits(in_word_t))) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_data   (rx_word),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (held_word)
  );

  // The framer state moves when the held word enters the result register.
  assign fire = mid_valid && mid_ready;

  bsfs_framer #(.MAX_MARK_BYTES(MAX_MARK_BYTES)) u_framer (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_q),
    .fire (fire),
    .word (held_word),
    .res  (res)
  );

  // Result register.
  bsfs_stage #(.W($bits(result_t))) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (res),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_data  (tx_word)
  );

  assign tx.out_byte   = tx_word.out_byte;
  assign tx.frame_last = tx_word.frame_last;
  assign tx.end_cause  = tx_word.end_cause;

endmodule
